### sv/sem_pkg.sv
// Shared types, constants and helper functions for the Sobel edge magnitude stream.
// Used by sem_isqrt and sobel_edge_magnitude_stream; depends on nothing else.
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = 10;
    localparam int SUM_W  = PIX_W + 2;
    localparam int SQ_W   = 2 * PIX_W + 1;
    localparam int SQRT_STEPS = PIX_W;
    localparam int STEP_W = $clog2(SQRT_STEPS);
    localparam int REM_W  = PIX_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] SIZE_MIN       = CFG_W'(3);
    localparam logic [CFG_W-1:0] WIDTH_LIMIT    = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT   = CFG_W'(MAX_HEIGHT);
    localparam logic [PIX_W-1:0] PIX_MAX        = {PIX_W{1'b1}};

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } sem_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             valid_res;
        logic             frame_end;
    } sem_out_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] value;
    } sem_sqrt_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] root;
    } sem_sqrt_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_SQUARE,
        ST_ROOT,
        ST_DONE
    } sem_state_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        if (v < SIZE_MIN) begin
            r = SIZE_MIN;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] grad_sat(input logic [SUM_W-1:0] plus,
                                                  input logic [SUM_W-1:0] minus);
        logic [SUM_W:0]   d;
        logic [PIX_W-1:0] r;
        d = {1'b0, plus} - {1'b0, minus};
        if (d[SUM_W]) begin
            r = '0;
        end else if (d[SUM_W-1:PIX_W] != '0) begin
            r = PIX_MAX;
        end else begin
            r = d[PIX_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/sem_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; holds one line of pixels for the Sobel edge magnitude stream.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/sem_isqrt.sv
// Iterative floor square root, two radicand bits per cycle, saturating at 255.
// Depends on sem_pkg for widths and the request and response structs.
module sem_isqrt (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sem_pkg::sem_sqrt_req_t req,
    output sem_pkg::sem_sqrt_rsp_t rsp
);
    import sem_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [2*PIX_W-1:0] rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  root_reg, root_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, rad_reg[2*PIX_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = ge ? (rem_sh - trial) : rem_sh;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (req.start) begin
            if (req.value[SQ_W-1]) begin
                root_next = PIX_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                rad_next  = req.value[2*PIX_W-1:0];
                rem_next  = '0;
                root_next = '0;
                cnt_next  = STEP_W'(SQRT_STEPS - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rad_next  = {rad_reg[2*PIX_W-3:0], 2'b00};
            rem_next  = rem_sub[REM_W-1:0];
            root_next = {root_reg[PIX_W-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    a_no_start_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("square root restarted while busy");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("square root done while still iterating");

    a_busy_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == '0 && !req.start) |=> done_reg)
        else $error("square root missed its last step");

endmodule

### sv/sobel_edge_magnitude_stream.sv
// Sobel edge magnitude over a raster pixel stream, two line RAMs and a 3x3 window.
// With the result register free, a transaction with a full window is loaded there after the
// line RAM update, the squares and the 8-step square root, one without after the RAM update.
// One transaction is in flight at a time; the next is accepted the cycle after that load.
// Synchronous active-low reset clears control, counters and window and sets the configuration to the maximum size.
module sobel_edge_magnitude_stream (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  sem_pkg::sem_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output sem_pkg::sem_out_t                m_data,
    input  logic                             cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sem_pkg::CFG_W-1:0]        cfg_wdata
);
    import sem_pkg::*;

    sem_state_t state_reg, state_next;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PIX_W-1:0] px_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] gx_reg, gy_reg;
    sem_out_t         res_reg, res_next;
    sem_out_t         out_next;
    logic             m_valid_reg;
    sem_out_t         m_data_reg;

    logic [COL_W-1:0] rd_col;
    logic [PIX_W-1:0] upper_rdata, middle_rdata;
    logic             ram_we;
    logic             sqrt_start;

    logic             s_accept, out_free, load_out;
    logic             win_full;
    logic [CFG_W-1:0] w_eff, h_eff;
    logic [CFG_W-1:0] col_inc, row_inc;
    logic [SUM_W-1:0] gx_plus, gx_minus, gy_plus, gy_minus;
    logic [SQ_W-2:0]  gx_sq, gy_sq;

    sem_sqrt_req_t sqrt_req;
    sem_sqrt_rsp_t sqrt_rsp;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_col   = s_data.frame_start ? '0 : col_reg;

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (middle_rdata),
        .raddr (rd_col),
        .rdata (upper_rdata)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (px_reg),
        .raddr (rd_col),
        .rdata (middle_rdata)
    );

    always_comb begin
        w_eff    = clamp_size(width_reg, WIDTH_LIMIT);
        h_eff    = clamp_size(height_reg, HEIGHT_LIMIT);
        col_inc  = CFG_W'(col_reg) + 1'b1;
        row_inc  = CFG_W'(row_reg) + 1'b1;
        win_full = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = upper_rdata;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = middle_rdata;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = px_reg;

        gx_plus  = SUM_W'(win_next[2]) + {1'b0, win_next[5], 1'b0} + SUM_W'(win_next[8]);
        gx_minus = SUM_W'(win_next[0]) + {1'b0, win_next[3], 1'b0} + SUM_W'(win_next[6]);
        gy_plus  = SUM_W'(win_next[6]) + {1'b0, win_next[7], 1'b0} + SUM_W'(win_next[8]);
        gy_minus = SUM_W'(win_next[0]) + {1'b0, win_next[1], 1'b0} + SUM_W'(win_next[2]);

        gx_sq = gx_reg * gx_reg;
        gy_sq = gy_reg * gy_reg;
        sqrt_req.value = {1'b0, gx_sq} + {1'b0, gy_sq};
        sqrt_req.start = sqrt_start;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept && s_data.frame_start) begin
            col_next = '0;
            row_next = '0;
        end else if (state_reg == ST_WIN) begin
            if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_comb begin
        res_next           = res_reg;
        res_next.magnitude = '0;
        res_next.out_row   = '0;
        res_next.out_col   = '0;
        res_next.valid_res = win_full;
        res_next.frame_end = (CFG_W'(row_reg) == h_eff - 1'b1) &&
                             (CFG_W'(col_reg) == w_eff - 1'b1);
        if (win_full) begin
            res_next.out_row = POS_W'(row_reg - ROW_W'(2));
            res_next.out_col = POS_W'(col_reg - COL_W'(2));
        end
        out_next           = res_reg;
        out_next.magnitude = res_reg.valid_res ? sqrt_rsp.root : '0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_WIN;
                end
            end
            ST_WIN: begin
                state_next = win_full ? ST_SQUARE : ST_DONE;
            end
            ST_SQUARE: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        ram_we     = 1'b0;
        sqrt_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_WIN:    ram_we     = 1'b1;
            ST_SQUARE: sqrt_start = 1'b1;
            ST_DONE:   load_out   = out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    sem_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= WIDTH_LIMIT;
            height_reg  <= HEIGHT_LIMIT;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            if (cfg_we && cfg_index == CFG_IDX_WIDTH) begin
                width_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_IDX_HEIGHT) begin
                height_reg <= cfg_wdata;
            end
            if (state_reg == ST_WIN) begin
                win_reg <= win_next;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg <= s_data.pixel;
        end
        if (state_reg == ST_WIN) begin
            gx_reg  <= grad_sat(gx_plus, gx_minus);
            gy_reg  <= grad_sat(gy_plus, gy_minus);
            res_reg <= res_next;
        end
        if (load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_to_win: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_WIN))
        else $error("accepted transaction did not enter the window step");

    a_root_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_rsp.done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside the root step");

    a_empty_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |->
            (m_data.magnitude == '0 && m_data.out_row == '0 && m_data.out_col == '0))
        else $error("result without a full window carries nonzero fields");

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten before transfer");

endmodule
